[hw/rtl/smw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smw_pkg: shared types and constants of the star map window threshold
// Field widths, register indexes, clamp limits and the result record types.
// ----------------------------------------------------------------------------
package smw_pkg;

    localparam int PIX_W      = 5;
    localparam int ROW_W      = 10;
    localparam int OCOL_W     = 7;
    localparam int SUM_W      = 8;
    localparam int ROWS_CFG_W = 11;
    localparam int COLS_CFG_W = 8;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;

    localparam int MAX_COLS_DEF = 128;

    // up to four results per pixel, plus one still waiting at the output
    localparam int MAX_RES     = 4;
    localparam int QUEUE_DEPTH = MAX_RES + 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 11'd6;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 8'd8;
    localparam logic [ROWS_CFG_W-1:0] ROWS_MIN   = 11'd2;
    localparam logic [ROWS_CFG_W-1:0] ROWS_MAX   = 11'd1024;
    localparam int                    COLS_MIN   = 2;

    localparam logic [PIX_W-1:0] PIX_CLAMP = 5'd20;

    // sum/5 > 10 is exactly sum > 50
    localparam int STAR_DIV    = 5;
    localparam int STAR_THRESH = 10;
    localparam logic [SUM_W-1:0] STAR_LIMIT = SUM_W'(STAR_DIV * STAR_THRESH);

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
        logic [SUM_W-1:0]  sum;
        logic              star;
        logic              last;
    } rec_t;

    typedef struct packed {
        rec_t [MAX_RES-1:0] rec;
        logic [CNT_W-1:0]   n;
    } res_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             ready;
    } q_stat_t;

    function automatic rec_t make_rec(input logic [ROW_W-1:0]  row,
                                      input logic [OCOL_W-1:0] col,
                                      input logic [SUM_W-1:0]  sum,
                                      input logic              last);
        rec_t r;
        r.row  = row;
        r.col  = col;
        r.sum  = sum;
        r.star = (sum > STAR_LIMIT);
        r.last = last;
        return r;
    endfunction

endpackage

[hw/rtl/smw_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smw_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module smw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/smw_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smw_core: raster position, line buffer and 3x3 window sums
// Keeps the two previous rows in a RAM and the two previous columns in
// registers, and builds the results that one pixel completes.
// ----------------------------------------------------------------------------
module smw_core #(
    parameter int MAX_COLS = smw_pkg::MAX_COLS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               accept,
    input  logic [smw_pkg::PIX_W-1:0]          pix_raw,
    input  logic [smw_pkg::ROWS_CFG_W-1:0]     rows_cfg,
    input  logic [smw_pkg::COLS_CFG_W-1:0]     cols_cfg,
    output smw_pkg::res_t                      res
);

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CMP_W = (COL_W + 1 > smw_pkg::COLS_CFG_W) ? COL_W + 1
                                                              : smw_pkg::COLS_CFG_W;
    localparam int PW    = smw_pkg::PIX_W;
    localparam int SW    = smw_pkg::SUM_W;
    localparam int RW    = smw_pkg::ROW_W;

    logic [RW-1:0]    row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [PW-1:0]    wc_reg [6];

    logic [PW-1:0]                     pix;
    logic [smw_pkg::ROWS_CFG_W-1:0]    rows_eff;
    logic [CMP_W-1:0]                  cols_ext, cols_eff;
    logic                              lastc, lastr, r_ge1, r_ge2, c_ge1, c_ge2, e1;
    logic [COL_W-1:0]                  raddr;
    logic [2*PW-1:0]                   rd, wdata;
    logic [PW-1:0]                     top2, mid2;
    logic [SW-1:0]                     lo0, lo1, lo2, hi0, hi1, hi2;
    logic [SW-1:0]                     sum_a, sum_b, sum_c, sum_d;
    logic [RW-1:0]                     rm1;
    logic [COL_W-1:0]                  cm1;
    logic [smw_pkg::OCOL_W-1:0]        oc, ocm1;
    smw_pkg::rec_t                     rec_b, rec_c;

    assign pix = (pix_raw > smw_pkg::PIX_CLAMP) ? smw_pkg::PIX_CLAMP : pix_raw;

    always_comb begin
        if (rows_cfg < smw_pkg::ROWS_MIN) begin
            rows_eff = smw_pkg::ROWS_MIN;
        end else if (rows_cfg > smw_pkg::ROWS_MAX) begin
            rows_eff = smw_pkg::ROWS_MAX;
        end else begin
            rows_eff = rows_cfg;
        end
    end

    assign cols_ext = CMP_W'(cols_cfg);

    always_comb begin
        if (cols_ext < CMP_W'(smw_pkg::COLS_MIN)) begin
            cols_eff = CMP_W'(smw_pkg::COLS_MIN);
        end else if (cols_ext > CMP_W'(MAX_COLS)) begin
            cols_eff = CMP_W'(MAX_COLS);
        end else begin
            cols_eff = cols_ext;
        end
    end

    assign lastc = (CMP_W'(col_reg) + CMP_W'(1)) >= cols_eff;
    assign lastr = (smw_pkg::ROWS_CFG_W'(row_reg) + smw_pkg::ROWS_CFG_W'(1)) >= rows_eff;
    assign r_ge1 = (row_reg != '0);
    assign r_ge2 = (row_reg >= RW'(2));
    assign c_ge1 = (col_reg != '0);
    assign c_ge2 = (CMP_W'(col_reg) >= CMP_W'(2));
    assign e1    = r_ge1 && c_ge1;

    assign col_next = lastc ? '0 : col_reg + COL_W'(1);

    always_comb begin
        row_next = row_reg;
        if (lastc) begin
            row_next = lastr ? '0 : row_reg + RW'(1);
        end
    end

    // read ahead: the word for the next pixel is ready when it arrives
    assign raddr = accept ? col_next : col_reg;
    // word layout: upper half two rows back, lower half one row back
    assign wdata = {rd[PW-1:0], pix};

    smw_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd)
    );

    assign top2 = rd[2*PW-1:PW];
    assign mid2 = rd[PW-1:0];

    // column sums: lo over the middle and bottom rows, hi adds the top row
    assign lo0 = SW'(wc_reg[4]) + SW'(wc_reg[5]);
    assign lo1 = SW'(wc_reg[1]) + SW'(wc_reg[2]);
    assign lo2 = SW'(mid2) + SW'(pix);
    assign hi0 = lo0 + (r_ge2 ? SW'(wc_reg[3]) : '0);
    assign hi1 = lo1 + (r_ge2 ? SW'(wc_reg[0]) : '0);
    assign hi2 = lo2 + (r_ge2 ? SW'(top2) : '0);

    assign sum_a = (c_ge2 ? hi0 : '0) + hi1 + hi2;
    assign sum_b = hi1 + hi2;
    assign sum_c = (c_ge2 ? lo0 : '0) + lo1 + lo2;
    assign sum_d = lo1 + lo2;

    assign rm1  = row_reg - RW'(1);
    assign cm1  = col_reg - COL_W'(1);
    assign oc   = smw_pkg::OCOL_W'(col_reg);
    assign ocm1 = smw_pkg::OCOL_W'(cm1);

    assign rec_b = smw_pkg::make_rec(rm1, oc, sum_b, !lastr);
    assign rec_c = smw_pkg::make_rec(row_reg, ocm1, sum_c, 1'b0);

    // order: above-left, above (last column), left (last row), own pixel
    always_comb begin
        if (!e1) begin
            res.n = '0;
        end else if (lastc && lastr) begin
            res.n = smw_pkg::CNT_W'(4);
        end else if (lastc || lastr) begin
            res.n = smw_pkg::CNT_W'(2);
        end else begin
            res.n = smw_pkg::CNT_W'(1);
        end
        res.rec[0] = smw_pkg::make_rec(rm1, ocm1, sum_a, !(lastc || lastr));
        res.rec[1] = lastc ? rec_b : rec_c;
        if (!lastc) begin
            res.rec[1].last = 1'b1;
        end
        res.rec[2] = rec_c;
        res.rec[3] = smw_pkg::make_rec(row_reg, oc, sum_d, 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
            for (int k = 0; k < 6; k++) begin
                wc_reg[k] <= '0;
            end
        end else if (accept) begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            wc_reg[3] <= wc_reg[0];
            wc_reg[4] <= wc_reg[1];
            wc_reg[5] <= wc_reg[2];
            wc_reg[0] <= top2;
            wc_reg[1] <= mid2;
            wc_reg[2] <= pix;
        end
    end

endmodule

[hw/rtl/smw_out_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smw_out_queue: result queue
// Takes the up to four results of one pixel at once and hands them out one
// per transfer; head slot drives the output.
// ----------------------------------------------------------------------------
module smw_out_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  smw_pkg::res_t      res,
    input  logic               m_tready,
    output logic               m_tvalid,
    output smw_pkg::rec_t      m_rec,
    output smw_pkg::q_stat_t   stat
);

    localparam int DEPTH = smw_pkg::QUEUE_DEPTH;
    localparam int CW    = smw_pkg::CNT_W;

    smw_pkg::rec_t    q_reg  [DEPTH];
    smw_pkg::rec_t    q_next [DEPTH];
    logic [CW-1:0]    cnt_reg, cnt_next, base;
    logic             run_reg;
    logic             take;

    assign m_tvalid = (cnt_reg != '0);
    assign take     = m_tvalid && m_tready;
    assign base     = cnt_reg - CW'(take);
    assign m_rec    = q_reg[0];

    assign stat.cnt   = cnt_reg;
    assign stat.ready = run_reg && (cnt_reg <= CW'(1));

    always_comb begin
        for (int i = 0; i < DEPTH - 1; i++) begin
            q_next[i] = take ? q_reg[i+1] : q_reg[i];
        end
        q_next[DEPTH-1] = q_reg[DEPTH-1];
        for (int i = 0; i < DEPTH; i++) begin
            for (int j = 0; j < smw_pkg::MAX_RES; j++) begin
                if (load && (CW'(j) < res.n) && (base + CW'(j) == CW'(i))) begin
                    q_next[i] = res.rec[j];
                end
            end
        end
        cnt_next = base + (load ? res.n : '0);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            run_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            run_reg <= 1'b1;
        end
    end

endmodule

[hw/rtl/star_map_window_threshold.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// star_map_window_threshold: streaming 3x3 brightness sum and star test
// Top level: configuration registers, window core and result queue.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one per transfer, and each is clamped to 20.
// A pixel that completes one result is followed by the next in the next cycle,
// even while the previous result is still held at the output. A pixel in the
// last column or last row completes two results and the final pixel of a frame
// four; the queue hands them out one per cycle while m_tready is high, and such
// a pixel holds off the input until at most one result is left, a limit set by
// the single output port of the result queue. The two previous rows sit in a
// MAX_COLS x 10 bit RAM whose registered read is fetched one pixel ahead. There
// is no clearing pass after reset. The user must write rows and columns per
// frame only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module star_map_window_threshold #(
    parameter int MAX_COLS = smw_pkg::MAX_COLS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [smw_pkg::S_TDATA_W-1:0]     s_tdata,   // [4:0] brightness
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [9:0] out_row, [16:10] out_col, [24:17] window_sum, [25] is_star
    output logic [smw_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast,   // run_end
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [smw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [smw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic [smw_pkg::ROWS_CFG_W-1:0] rows_reg;
    logic [smw_pkg::COLS_CFG_W-1:0] cols_reg;
    logic                           load;
    smw_pkg::res_t                  res;
    smw_pkg::rec_t                  rec;
    smw_pkg::q_stat_t               stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= smw_pkg::ROWS_RESET;
            cols_reg <= smw_pkg::COLS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                smw_pkg::REG_ROWS: rows_reg <= cfg_wdata[smw_pkg::ROWS_CFG_W-1:0];
                smw_pkg::REG_COLS: cols_reg <= cfg_wdata[smw_pkg::COLS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = stat.ready;
    assign load     = s_tvalid && s_tready;

    smw_core #(
        .MAX_COLS (MAX_COLS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (load),
        .pix_raw  (s_tdata[smw_pkg::PIX_W-1:0]),
        .rows_cfg (rows_reg),
        .cols_cfg (cols_reg),
        .res      (res)
    );

    smw_out_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .res      (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_rec    (rec),
        .stat     (stat)
    );

    assign m_tdata = {6'b0, rec.star, rec.sum, rec.col, rec.row};
    assign m_tlast = rec.last;

`ifndef SYNTHESIS
    // queue never holds more than one waiting result plus one pixel's worth
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.cnt <= smw_pkg::CNT_W'(smw_pkg::QUEUE_DEPTH))
        else $error("result queue overfilled");

    // a result that is not the last of its pixel always has a successor queued
    a_run_whole: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |-> (stat.cnt >= smw_pkg::CNT_W'(2)))
        else $error("result run broken up");

    // a pixel completes none, one, two or four results
    a_res_count: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (res.n == smw_pkg::CNT_W'(0) || res.n == smw_pkg::CNT_W'(1) ||
                  res.n == smw_pkg::CNT_W'(2) || res.n == smw_pkg::CNT_W'(4)))
        else $error("bad result count for a pixel");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking regression for star_map_window_threshold
// Streams brightness frames in raster order and predicts every classified
// pixel (coordinates, 3x3 window sum, star flag, run end) from a local model
// of the line buffers and window. Results are matched in order as they are
// transferred. Covers reset shape, directed edge cases, register saturation,
// random frames under varying idle patterns and long output back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int LINE_DEPTH    = smw_pkg::MAX_COLS_DEF;
    localparam int PIX_CEIL      = 20;
    localparam int STAR_SUM      = 50;
    localparam int RANDOM_PIXELS = 150;

    typedef logic [smw_pkg::PIX_W-1:0] nbhd_t [3][3];

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic [smw_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                           m_tready  = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [smw_pkg::CFG_IDX_W-1:0]  cfg_index = smw_pkg::REG_ROWS;
    logic [smw_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    wire                            s_tready;
    wire                            m_tvalid;
    wire                            m_tlast;
    wire  [smw_pkg::M_TDATA_W-1:0]  m_tdata;

    // model state
    logic [smw_pkg::PIX_W-1:0]      row_above2 [LINE_DEPTH] = '{default: '0};
    logic [smw_pkg::PIX_W-1:0]      row_above1 [LINE_DEPTH] = '{default: '0};
    logic [smw_pkg::PIX_W-1:0]      col_hist [6] = '{default: '0};
    int                             next_row = 0;
    int                             next_col = 0;
    logic [smw_pkg::ROWS_CFG_W-1:0] cfg_rows = smw_pkg::ROWS_RESET;
    logic [smw_pkg::COLS_CFG_W-1:0] cfg_cols = smw_pkg::COLS_RESET;

    smw_pkg::rec_t pending_verdicts [$];
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    int            send_idle_pct  = 0;
    int            recv_idle_pct  = 0;
    int            hold_left      = 0;

    star_map_window_threshold dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output side: random stalls, or a long hold requested by a test
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic int eff_rows();
        int v;
        v = cfg_rows;
        if (v < 2) v = 2;
        if (v > 1024) v = 1024;
        return v;
    endfunction

    function automatic int eff_cols();
        int v;
        v = cfg_cols;
        if (v < 2) v = 2;
        if (v > LINE_DEPTH) v = LINE_DEPTH;
        return v;
    endfunction

    function automatic int frame_pixels();
        return eff_rows() * eff_cols();
    endfunction

    // window rows k0..2 and columns m0..2; column 2 is the newest
    function automatic logic [smw_pkg::SUM_W-1:0] window_total(nbhd_t g, int k0, int m0);
        logic [smw_pkg::SUM_W-1:0] acc;
        acc = '0;
        for (int k = k0; k < 3; k++)
            for (int m = m0; m < 3; m++)
                acc = acc + smw_pkg::SUM_W'(g[k][m]);
        return acc;
    endfunction

    function automatic smw_pkg::rec_t build_verdict(int row, int col,
                                                    logic [smw_pkg::SUM_W-1:0] sum);
        smw_pkg::rec_t v;
        v.row  = smw_pkg::ROW_W'(row);
        v.col  = smw_pkg::OCOL_W'(col);
        v.sum  = sum;
        v.star = (sum > STAR_SUM);
        v.last = 1'b0;
        return v;
    endfunction

    function automatic void classify_pixel(logic [smw_pkg::PIX_W-1:0] raw);
        logic [smw_pkg::PIX_W-1:0] pix;
        nbhd_t                     g;
        smw_pkg::rec_t             batch [$];
        int                        rows, cols, idx, k0, m0;
        bit                        lastc, lastr;
        pix   = (raw > PIX_CEIL) ? smw_pkg::PIX_W'(PIX_CEIL) : raw;
        rows  = eff_rows();
        cols  = eff_cols();
        idx   = next_col % LINE_DEPTH;
        for (int k = 0; k < 3; k++) begin
            g[k][0] = col_hist[3 + k];
            g[k][1] = col_hist[k];
        end
        g[0][2] = row_above2[idx];
        g[1][2] = row_above1[idx];
        g[2][2] = pix;
        lastc = (next_col + 1 >= cols);
        lastr = (next_row + 1 >= rows);
        k0    = (next_row >= 2) ? 0 : 1;
        m0    = (next_col >= 2) ? 0 : 1;

        // the pixel up-left is complete; last column/row flush the rest
        if (next_row >= 1 && next_col >= 1) begin
            batch.push_back(build_verdict(next_row - 1, next_col - 1,
                                          window_total(g, k0, m0)));
            if (lastc)
                batch.push_back(build_verdict(next_row - 1, next_col,
                                              window_total(g, k0, 1)));
            if (lastr)
                batch.push_back(build_verdict(next_row, next_col - 1,
                                              window_total(g, 1, m0)));
            if (lastr && lastc)
                batch.push_back(build_verdict(next_row, next_col, window_total(g, 1, 1)));
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            pending_verdicts.push_back(batch[i]);

        row_above2[idx] = row_above1[idx];
        row_above1[idx] = pix;
        for (int k = 0; k < 3; k++) begin
            col_hist[3 + k] = col_hist[k];
            col_hist[k]     = g[k][2];
        end
        if (lastc) begin
            next_col = 0;
            next_row = lastr ? 0 : next_row + 1;
        end else begin
            next_col = next_col + 1;
        end
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count = mismatch_count + 1;
    endtask

    always @(posedge aclk) begin
        smw_pkg::rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                flag_mismatch($sformatf("unexpected result tdata=%h tlast=%b",
                                        m_tdata, m_tlast));
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[smw_pkg::ROW_W-1:0] !== want.row)
                    flag_mismatch($sformatf("out_row got %0d exp %0d (col %0d)",
                                            m_tdata[smw_pkg::ROW_W-1:0], want.row,
                                            want.col));
                if (m_tdata[smw_pkg::ROW_W +: smw_pkg::OCOL_W] !== want.col)
                    flag_mismatch($sformatf("out_col got %0d exp %0d (row %0d)",
                                            m_tdata[smw_pkg::ROW_W +: smw_pkg::OCOL_W],
                                            want.col, want.row));
                if (m_tdata[smw_pkg::ROW_W+smw_pkg::OCOL_W +: smw_pkg::SUM_W] !== want.sum)
                    flag_mismatch($sformatf("window_sum got %0d exp %0d at (%0d,%0d)",
                        m_tdata[smw_pkg::ROW_W+smw_pkg::OCOL_W +: smw_pkg::SUM_W],
                        want.sum, want.row, want.col));
                if (m_tdata[smw_pkg::ROW_W+smw_pkg::OCOL_W+smw_pkg::SUM_W] !== want.star)
                    flag_mismatch($sformatf("is_star got %b exp %b at (%0d,%0d)",
                        m_tdata[smw_pkg::ROW_W+smw_pkg::OCOL_W+smw_pkg::SUM_W],
                        want.star, want.row, want.col));
                if (m_tlast !== want.last)
                    flag_mismatch($sformatf("run_end got %b exp %b at (%0d,%0d)",
                                            m_tlast, want.last, want.row, want.col));
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_pixel(logic [smw_pkg::PIX_W-1:0] bright);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smw_pkg::S_TDATA_W'(bright);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        classify_pixel(bright);
    endtask

    task automatic send_frame(int lo, int hi);
        int n;
        n = frame_pixels();
        repeat (n) send_pixel(smw_pkg::PIX_W'($urandom_range(hi, lo)));
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_verdicts.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [smw_pkg::CFG_IDX_W-1:0] idx, int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= smw_pkg::CFG_DATA_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == smw_pkg::REG_ROWS)
            cfg_rows = smw_pkg::ROWS_CFG_W'(value);
        else
            cfg_cols = smw_pkg::COLS_CFG_W'(value);
    endtask

    // only with the pipeline empty
    task automatic load_frame_shape(int rows, int cols);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(smw_pkg::REG_ROWS, rows);
        write_reg(smw_pkg::REG_COLS, cols);
    endtask

    task automatic set_idling(int sender_pct, int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_shape();
        set_idling(28, 47);
        send_frame(0, 31);
    endtask

    task automatic test_directed_cases();
        // everything clamps to 20: corners 80, edges 120, centre 180
        logic [smw_pkg::PIX_W-1:0] bright_sat [9] = '{5'd31, 5'd21, 5'd20, 5'd31, 5'd30,
                                                      5'd22, 5'd25, 5'd20, 5'd31};
        // 2x2 frames: every result sums all four, right on and just over the bar
        logic [smw_pkg::PIX_W-1:0] on_bar [4]   = '{5'd20, 5'd20, 5'd10, 5'd0};
        logic [smw_pkg::PIX_W-1:0] over_bar [4] = '{5'd20, 5'd20, 5'd11, 5'd0};
        set_idling(0, 0);
        load_frame_shape(3, 3);
        foreach (bright_sat[i]) send_pixel(bright_sat[i]);
        s_tvalid <= 1'b0;
        load_frame_shape(2, 2);
        foreach (on_bar[i]) send_pixel(on_bar[i]);
        foreach (over_bar[i]) send_pixel(over_bar[i]);
        s_tvalid <= 1'b0;
        load_frame_shape(2, 3);
        send_frame(0, 0);
    endtask

    task automatic test_register_limits();
        set_idling(0, 0);
        load_frame_shape(0, 1);       // saturates to 2 x 2
        send_frame(0, 31);
        // 2047 saturates to 1024 rows: three rows in, the frame is still open
        load_frame_shape(2047, 2);
        repeat (6) send_pixel(smw_pkg::PIX_W'($urandom_range(31, 0)));
        s_tvalid <= 1'b0;
        // shrink to four rows while idle: the fourth row closes the frame
        load_frame_shape(4, 2);
        repeat (2) send_pixel(smw_pkg::PIX_W'($urandom_range(31, 0)));
        s_tvalid <= 1'b0;
    endtask

    task automatic test_random_frames();
        int sent, rows, cols, lo, hi, pick;
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: set_idling(28, 47);
                1: set_idling(47, 28);
                default: set_idling(0, 0);
            endcase
            sent = 0;
            while (sent < RANDOM_PIXELS / 3) begin
                pick = $urandom_range(0, 9);
                rows = (pick < 8) ? $urandom_range(2, 6) : $urandom_range(0, 3);
                if (pick < 6)
                    cols = $urandom_range(2, 10);
                else if (pick < 8)
                    cols = $urandom_range(11, 20);
                else
                    cols = $urandom_range(0, 3);
                case ($urandom_range(0, 2))
                    0: begin lo = 0;  hi = 31; end
                    1: begin lo = 12; hi = 31; end
                    default: begin lo = 0; hi = 9; end
                endcase
                load_frame_shape(rows, cols);
                send_frame(lo, hi);
                sent = sent + frame_pixels();
            end
        end
    endtask

    task automatic test_output_backpressure();
        int half;
        set_idling(0, 47);
        load_frame_shape(6, 8);
        half = frame_pixels() / 2;
        @(negedge aclk);
        hold_left = HOLD_CYCLES;
        @(posedge aclk);
        // sender keeps offering while the output is held off
        repeat (half) send_pixel(smw_pkg::PIX_W'($urandom_range(31, 0)));
        s_tvalid <= 1'b0;
        wait_drained();
        set_idling(28, 47);
        repeat (frame_pixels() - half) send_pixel(smw_pkg::PIX_W'($urandom_range(31, 0)));
        s_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_shape();
        test_directed_cases();
        test_register_limits();
        test_random_frames();
        test_output_backpressure();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_verdicts.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
